// ----- design/etf_pkg.sv -----
// Shared types and constants for the escape-time fractal pixel block.
`default_nettype none

package etf_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int COORD_BITS     = 32;
   localparam int PHASE_BITS     = 6;
   localparam int COUNT_BITS     = 16;
   localparam int SHADE_BITS     = 4;
   localparam int COLOR_BITS     = 7;

   localparam logic signed [COORD_BITS-1:0] JULIA_REAL_RESET = -32'sd107374182;
   localparam logic signed [COORD_BITS-1:0] JULIA_IMAG_RESET = 32'sd161061274;
   localparam logic [COUNT_BITS-1:0]        ITER_LIMIT_RESET = 16'd1000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRACTAL_MODE = 2'd0,
      CSR_JULIA_REAL   = 2'd1,
      CSR_JULIA_IMAG   = 2'd2,
      CSR_ITER_LIMIT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                         fractal_mode;
      logic signed [COORD_BITS-1:0] julia_const_real;
      logic signed [COORD_BITS-1:0] julia_const_imag;
      logic [COUNT_BITS-1:0]        iteration_limit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic square;
      logic update;
      logic finish;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic stop;
      logic escape;
      logic step_last;
   } status_type;

endpackage

`default_nettype wire

// ----- design/etf_channels.sv -----
// Valid/ready channel interfaces for pixel requests and results.
`default_nettype none

interface etf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_real;
   logic signed [31:0] point_imag;
   logic [5:0]         color_phase;

   modport source (output valid, output point_real, output point_imag,
                   output color_phase, input ready);
   modport sink (input valid, input point_real, input point_imag,
                 input color_phase, output ready);
endinterface

interface etf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] iteration_count;
   logic        inside_set;
   logic [3:0]  shade_level;
   logic [6:0]  color_index;

   modport source (output valid, output iteration_count, output inside_set,
                   output shade_level, output color_index, input ready);
   modport sink (input valid, input iteration_count, input inside_set,
                 input shade_level, input color_index, output ready);
endinterface

`default_nettype wire

// ----- design/etf_csr.sv -----
// Configuration register file.
`default_nettype none

module etf_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [etf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [etf_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output etf_pkg::cfg_type                        cfg
);
   import etf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRACTAL_MODE: cfg_in.fractal_mode     = csr_wdata[0];
            CSR_JULIA_REAL:   cfg_in.julia_const_real = csr_wdata;
            CSR_JULIA_IMAG:   cfg_in.julia_const_imag = csr_wdata;
            CSR_ITER_LIMIT:   cfg_in.iteration_limit  = csr_wdata[COUNT_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fractal_mode     <= 1'b0;
         cfg_ff.julia_const_real <= JULIA_REAL_RESET;
         cfg_ff.julia_const_imag <= JULIA_IMAG_RESET;
         cfg_ff.iteration_limit  <= ITER_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- design/etf_ctrl.sv -----
// Sequencer: square/update iteration loop, divide steps and result handoff.
`default_nettype none

module etf_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire etf_pkg::status_type status,
   output etf_pkg::cmd_type         cmd
);
   import etf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_UPDATE,
      ST_FINISH,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (status.stop) begin
               state_in = ST_FINISH;
            end else begin
               cmd.square = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (status.escape) begin
               state_in = ST_FINISH;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_SQUARE;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.step_last) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/etf_datapath.sv -----
// Iteration datapath, shade divider, color reduction and result register.
`default_nettype none

module etf_datapath #(
   parameter int FRACTION_BITS = 28,
   parameter int SHADE_LEVELS  = 10,
   parameter int COLOR_COUNT   = 64
) (
   input  wire logic                                  clock,
   input  wire etf_pkg::cfg_type                      cfg,
   input  wire etf_pkg::cmd_type                      cmd,
   input  wire logic signed [etf_pkg::COORD_BITS-1:0] point_real,
   input  wire logic signed [etf_pkg::COORD_BITS-1:0] point_imag,
   input  wire logic [etf_pkg::PHASE_BITS-1:0]        color_phase,
   output etf_pkg::status_type                        status,
   output logic [etf_pkg::COUNT_BITS-1:0]             iteration_count,
   output logic                                       inside_set,
   output logic [etf_pkg::SHADE_BITS-1:0]             shade_level,
   output logic [etf_pkg::COLOR_BITS-1:0]             color_index
);
   import etf_pkg::*;

   localparam int F     = FRACTION_BITS;
   localparam int ZW    = (F > 22) ? F + 12 : 34;
   localparam int MW    = F + 1;
   localparam int PW    = 2 * MW;
   localparam int SW    = PW + 1;
   localparam int STEPS = ($clog2(SHADE_LEVELS) > 5) ? $clog2(SHADE_LEVELS) : 5;
   localparam int SCW   = $clog2(STEPS);
   localparam int RW    = COUNT_BITS + STEPS;
   localparam int CW    = $clog2(COLOR_COUNT);
   localparam int CW1   = $clog2(COLOR_COUNT + 1);
   localparam int CXW   = (CW1 + 2 > COLOR_BITS) ? CW1 + 2 : COLOR_BITS;
   localparam int PHN   = 2 ** PHASE_BITS;

   // phase modulo color count, one entry per phase value
   function automatic logic [PHN*CW-1:0] phase_mod_table();
      logic [PHN*CW-1:0] tab;
      tab = '0;
      for (int k = 0; k < PHN; k++) begin
         tab[k*CW +: CW] = CW'(k % COLOR_COUNT);
      end
      return tab;
   endfunction

   localparam logic [CW-1:0]     CMOD_MAX      = CW'(COLOR_COUNT - 1);
   localparam logic [CXW-1:0]    COLOR_LIM     = CXW'(COLOR_COUNT);
   localparam logic [PHN*CW-1:0] PHASE_MOD_TAB = phase_mod_table();

   logic signed [ZW-1:0]   zr_ff, zr_in, zi_ff, zi_in;
   logic signed [ZW-1:0]   cr_ff, cr_in, ci_ff, ci_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [CW-1:0]          cmod_ff, cmod_in;
   logic [PW-1:0]          sr_ff, sr_in, si_ff, si_in, cross_ff, cross_in;
   logic                   neg_ff, neg_in;
   logic [RW-1:0]          rem_ff, rem_in, dvs_ff, dvs_in;
   logic [STEPS-1:0]       quo_ff, quo_in;
   logic [CW-1:0]          prem_ff, prem_in;
   logic [SCW-1:0]         step_ff, step_in;
   logic [COUNT_BITS-1:0]  out_count_ff, out_count_in;
   logic                   out_inside_ff, out_inside_in;
   logic [SHADE_BITS-1:0]  out_shade_ff, out_shade_in;
   logic [COLOR_BITS-1:0]  out_color_ff, out_color_in;

   logic [ZW-1:0]          absr, absi;
   logic                   big;
   logic [SW-1:0]          mag_sum, diff, cross_s;
   logic [F+2:0]           re_sh;
   logic [F+3:0]           im_sh;
   logic signed [ZW-1:0]   zr_next, zi_next;
   logic signed [ZW-1:0]   pr_ext, pi_ext, jr_ext, ji_ext;
   logic [CXW-1:0]         csum, cwrap, cidx;
   logic                   limit_hit;

   assign absr = zr_ff[ZW-1] ? ZW'(-zr_ff) : ZW'(zr_ff);
   assign absi = zi_ff[ZW-1] ? ZW'(-zi_ff) : ZW'(zi_ff);
   assign big  = (|absr[ZW-1:MW]) || (|absi[ZW-1:MW]);

   assign mag_sum = {1'b0, sr_ff} + {1'b0, si_ff};
   assign diff    = {1'b0, sr_ff} - {1'b0, si_ff};
   assign cross_s = neg_ff ? SW'(-{1'b0, cross_ff}) : {1'b0, cross_ff};
   assign re_sh   = diff[SW-1:F];
   assign im_sh   = cross_s[SW-1:F-1];
   assign zr_next = {{(ZW-F-3){re_sh[F+2]}}, re_sh} + cr_ff;
   assign zi_next = {{(ZW-F-4){im_sh[F+3]}}, im_sh} + ci_ff;

   assign pr_ext = {{(ZW-COORD_BITS){point_real[COORD_BITS-1]}}, point_real};
   assign pi_ext = {{(ZW-COORD_BITS){point_imag[COORD_BITS-1]}}, point_imag};
   assign jr_ext = {{(ZW-COORD_BITS){cfg.julia_const_real[COORD_BITS-1]}},
                    cfg.julia_const_real};
   assign ji_ext = {{(ZW-COORD_BITS){cfg.julia_const_imag[COORD_BITS-1]}},
                    cfg.julia_const_imag};

   assign limit_hit = (count_ff == cfg.iteration_limit);
   assign csum      = CXW'(cmod_ff) + CXW'(prem_ff);
   assign cwrap     = (csum >= COLOR_LIM) ? csum - COLOR_LIM : csum;
   assign cidx      = cwrap + CXW'(1);

   assign status.stop      = (count_ff >= cfg.iteration_limit) || big;
   assign status.escape    = mag_sum[SW-1];
   assign status.step_last = (step_ff == '0);

   always_comb begin
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      count_in      = count_ff;
      cmod_in       = cmod_ff;
      sr_in         = sr_ff;
      si_in         = si_ff;
      cross_in      = cross_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      quo_in        = quo_ff;
      prem_in       = prem_ff;
      step_in       = step_ff;
      out_count_in  = out_count_ff;
      out_inside_in = out_inside_ff;
      out_shade_in  = out_shade_ff;
      out_color_in  = out_color_ff;

      if (cmd.load) begin
         if (cfg.fractal_mode) begin
            zr_in = pr_ext;
            zi_in = pi_ext;
            cr_in = jr_ext;
            ci_in = ji_ext;
         end else begin
            zr_in = '0;
            zi_in = '0;
            cr_in = pr_ext;
            ci_in = pi_ext;
         end
         count_in = '0;
         cmod_in  = '0;
         prem_in  = PHASE_MOD_TAB[32'(color_phase) * CW +: CW];
      end

      if (cmd.square) begin
         sr_in    = absr[MW-1:0] * absr[MW-1:0];
         si_in    = absi[MW-1:0] * absi[MW-1:0];
         cross_in = absr[MW-1:0] * absi[MW-1:0];
         neg_in   = zr_ff[ZW-1] ^ zi_ff[ZW-1];
      end

      if (cmd.update) begin
         zr_in    = zr_next;
         zi_in    = zi_next;
         count_in = count_ff + COUNT_BITS'(1);
         cmod_in  = (cmod_ff == CMOD_MAX) ? '0 : cmod_ff + CW'(1);
      end

      if (cmd.finish) begin
         rem_in  = RW'(count_ff) * RW'(SHADE_LEVELS);
         dvs_in  = RW'(cfg.iteration_limit) << (STEPS - 1);
         quo_in  = '0;
         step_in = SCW'(STEPS - 1);
      end

      // restoring divide for the shade
      if (cmd.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            quo_in = {quo_ff[STEPS-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[STEPS-2:0], 1'b0};
         end
         dvs_in  = dvs_ff >> 1;
         step_in = step_ff - SCW'(1);
      end

      if (cmd.out_load) begin
         out_count_in  = count_ff;
         out_inside_in = limit_hit;
         out_shade_in  = limit_hit ? '0 : quo_ff[SHADE_BITS-1:0];
         out_color_in  = limit_hit ? '0 : cidx[COLOR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      count_ff      <= count_in;
      cmod_ff       <= cmod_in;
      sr_ff         <= sr_in;
      si_ff         <= si_in;
      cross_ff      <= cross_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      quo_ff        <= quo_in;
      prem_ff       <= prem_in;
      step_ff       <= step_in;
      out_count_ff  <= out_count_in;
      out_inside_ff <= out_inside_in;
      out_shade_ff  <= out_shade_in;
      out_color_ff  <= out_color_in;
   end

   assign iteration_count = out_count_ff;
   assign inside_set      = out_inside_ff;
   assign shade_level     = out_shade_ff;
   assign color_index     = out_color_ff;

endmodule

`default_nettype wire

// ----- design/escape_time_fractal_pixel.sv -----
// Top level of the escape-time fractal pixel evaluator.
//
// req_ch carries one point (signed Q4.28 real and imaginary part) and a
// color phase; a transfer happens when valid and ready are both high.
// rsp_ch returns one result per point: iteration count, inside flag, shade
// level and color index. csr_we/csr_index/csr_wdata write the mode, the
// Julia constant and the iteration limit; write them only while idle.
// One point is evaluated at a time. Each iteration has a squaring step,
// which runs the three squaring multipliers, and an update step, which does
// the escape test and z update; the escape shows in the squared magnitude.
// The restoring divider that forms the shade level takes STEPS steps, with
// STEPS = max(5, clog2(SHADE_LEVELS)) (5 by default).
// The result sits in an output register, so the next point is taken while
// a result waits; if the receiver stalls, the following result holds in
// the datapath until the output register frees up.
// Reset clears the sequencer and the output valid and restores the
// configuration defaults.
`default_nettype none

module escape_time_fractal_pixel #(
   parameter int FRACTION_BITS = 28,
   parameter int SHADE_LEVELS  = 10,
   parameter int COLOR_COUNT   = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   etf_req_if.sink                                 req_ch,
   etf_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_we,
   input  wire logic [etf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [etf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import etf_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   etf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   etf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   etf_datapath #(
      .FRACTION_BITS (FRACTION_BITS),
      .SHADE_LEVELS  (SHADE_LEVELS),
      .COLOR_COUNT   (COLOR_COUNT)
   ) u_datapath (
      .clock           (clock),
      .cfg             (cfg),
      .cmd             (cmd),
      .point_real      (req_ch.point_real),
      .point_imag      (req_ch.point_imag),
      .color_phase     (req_ch.color_phase),
      .status          (status),
      .iteration_count (rsp_ch.iteration_count),
      .inside_set      (rsp_ch.inside_set),
      .shade_level     (rsp_ch.shade_level),
      .color_index     (rsp_ch.color_index)
   );

endmodule

`default_nettype wire

// ----- design/etf_checker.sv -----
// Port-level checks for the fractal pixel block, bound to the top level.
`default_nettype none

module etf_checker #(
   parameter int SHADE_LEVELS = 10
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_inside,
   input wire logic [3:0] rsp_shade,
   input wire logic [6:0] rsp_color
);

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_inside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside |-> rsp_shade == 4'd0 && rsp_color == 7'd0)
      else $error("inside point with nonzero shade or color");

   a_outside_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside |-> rsp_color != 7'd0 && rsp_shade < SHADE_LEVELS)
      else $error("escaped point with bad shade or color");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind escape_time_fractal_pixel etf_checker #(.SHADE_LEVELS(SHADE_LEVELS)) u_etf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_inside (rsp_ch.inside_set),
   .rsp_shade  (rsp_ch.shade_level),
   .rsp_color  (rsp_ch.color_index)
);

`default_nettype wire
